FILE: sv/tcac_pkg.sv
// Shared types, constants and color helpers for the text console block.
`timescale 1ns / 1ps
package tcac_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int CMD_DEPTH   = 4;
	localparam int RES_DEPTH   = 4;

	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_M      = 8'h6D;

	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [2:0] TAB_WRITES = 3'd4;

	// Work for the back end, one per accepted byte
	typedef enum logic [2:0] {
		OP_NONE      = 3'd0,
		OP_PLAIN     = 3'd1,
		OP_TAB       = 3'd2,
		OP_NEWLINE   = 3'd3,
		OP_BACKSPACE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PM_NORMAL = 4'b0001,
		PM_ESC    = 4'b0010,
		PM_CSI    = 4'b0100,
		PM_SKIP   = 4'b1000
	} parse_t;

	// ANSI color index to display palette index
	function automatic logic [2:0] colour_map(input logic [2:0] c);
		logic [2:0] m;
		case (c)
			3'd0: m = 3'd0;
			3'd1: m = 3'd4;
			3'd2: m = 3'd2;
			3'd3: m = 3'd6;
			3'd4: m = 3'd1;
			3'd5: m = 3'd5;
			3'd6: m = 3'd3;
			default: m = 3'd7;
		endcase
		return m;
	endfunction

	// SGR code applied to the current attribute
	function automatic logic [7:0] apply_code(input logic [7:0] attr, input logic [9:0] v);
		logic [7:0] a;
		a = attr;
		if (v == 10'd0)
			a = ATTR_RESET;
		else if (v inside {[10'd30:10'd37]})
			a = {attr[7:4], 1'b0, colour_map(3'(v - 10'd30))};
		else if (v inside {[10'd90:10'd97]})
			a = {attr[7:4], 1'b1, colour_map(3'(v - 10'd90))};
		else if (v inside {[10'd40:10'd47]})
			a = {1'b0, colour_map(3'(v - 10'd40)), attr[3:0]};
		else if (v inside {[10'd100:10'd107]})
			a = {1'b1, colour_map(3'(v - 10'd100)), attr[3:0]};
		return a;
	endfunction

endpackage

FILE: sv/tcac_fifo.sv
// Small first-word-fall-through queue used between and after the stages.
`timescale 1ns / 1ps
module tcac_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/tcac_front.sv
// Front end: escape parser, color attribute and byte classification.
`timescale 1ns / 1ps
module tcac_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        in_byte,
	input  logic              cmd_full,
	output logic              cmd_push,
	output tcac_pkg::op_t     cmd_op
);
	tcac_pkg::parse_t mode_q, mode_d;
	logic [1:0]       csi_count_q, csi_count_d;
	logic [9:0]       csi_value_q, csi_value_d;
	logic             digits_ended_q, digits_ended_d;
	logic [7:0]       attr_q, attr_d;
	tcac_pkg::op_t    normal_op, op_d;
	logic             accept;

	assign accept   = push && !cmd_full;
	assign cmd_push = accept;
	assign cmd_op   = op_d;

	// Classification of a byte seen outside an escape sequence
	always_comb begin
		case (in_byte)
			tcac_pkg::CH_ESC: normal_op = tcac_pkg::OP_NONE;
			tcac_pkg::CH_LF:  normal_op = tcac_pkg::OP_NEWLINE;
			tcac_pkg::CH_BS:  normal_op = tcac_pkg::OP_BACKSPACE;
			tcac_pkg::CH_TAB: normal_op = tcac_pkg::OP_TAB;
			default:          normal_op = tcac_pkg::OP_PLAIN;
		endcase
	end

	always_comb begin
		mode_d         = mode_q;
		csi_count_d    = csi_count_q;
		csi_value_d    = csi_value_q;
		digits_ended_d = digits_ended_q;
		attr_d         = attr_q;
		op_d           = tcac_pkg::OP_NONE;
		case (mode_q)
			tcac_pkg::PM_NORMAL: begin
				op_d = normal_op;
				if (in_byte == tcac_pkg::CH_ESC)
					mode_d = tcac_pkg::PM_ESC;
			end
			tcac_pkg::PM_ESC: begin
				if (in_byte == tcac_pkg::CH_LBRACK) begin
					mode_d         = tcac_pkg::PM_CSI;
					csi_count_d    = '0;
					csi_value_d    = '0;
					digits_ended_d = 1'b0;
				end else if (in_byte != tcac_pkg::CH_ESC) begin
					// stray ESC: drop it and treat this byte as ordinary
					mode_d = tcac_pkg::PM_NORMAL;
					op_d   = normal_op;
				end
			end
			tcac_pkg::PM_CSI: begin
				if (in_byte == tcac_pkg::CH_M) begin
					attr_d = tcac_pkg::apply_code(attr_q, csi_value_q);
					mode_d = tcac_pkg::PM_NORMAL;
				end else begin
					if (!digits_ended_q &&
					    (in_byte inside {[tcac_pkg::CH_ZERO:tcac_pkg::CH_NINE]}))
						csi_value_d = (csi_value_q << 3) + (csi_value_q << 1) +
						              10'(in_byte - tcac_pkg::CH_ZERO);
					else
						digits_ended_d = 1'b1;
					csi_count_d = csi_count_q + 1'b1;
					if (csi_count_q == 2'd2)
						mode_d = tcac_pkg::PM_SKIP;
				end
			end
			default: begin
				// byte after three parameter characters is swallowed
				attr_d = tcac_pkg::apply_code(attr_q, csi_value_q);
				mode_d = tcac_pkg::PM_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= tcac_pkg::PM_NORMAL;
			csi_count_q    <= '0;
			csi_value_q    <= '0;
			digits_ended_q <= 1'b0;
			attr_q         <= tcac_pkg::ATTR_RESET;
		end else if (accept) begin
			mode_q         <= mode_d;
			csi_count_q    <= csi_count_d;
			csi_value_q    <= csi_value_d;
			digits_ended_q <= digits_ended_d;
			attr_q         <= attr_d;
		end
	end

endmodule

FILE: sv/tcac_back.sv
// Back end: cursor keeper making result kinds, one per cycle unless res_full.
`timescale 1ns / 1ps
module tcac_back #(
	parameter int COLUMNS = tcac_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcac_pkg::ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  tcac_pkg::op_t      cmd_op,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output tcac_pkg::kind_t    res_kind
);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic [CW-1:0] col_q, ecol, ncol;
	logic [RW-1:0] row_q, erow, nrow;
	logic          blank_q, scroll_q, cursor_q;
	logic [2:0]    wr_left_q;
	logic          eb, es, ec, nb, ns, nc;
	logic [2:0]    ew, nw;
	logic          busy, load, emit;

	assign busy = blank_q || scroll_q || cursor_q || (wr_left_q != '0);
	assign load = !busy && cmd_valid;

	// Pending work seen this cycle: registers, or a command loaded now
	always_comb begin
		ecol = col_q;
		erow = row_q;
		eb   = blank_q;
		es   = scroll_q;
		ew   = wr_left_q;
		ec   = cursor_q;
		if (load) begin
			ec = 1'b1;
			case (cmd_op)
				tcac_pkg::OP_PLAIN: ew = 3'd1;
				tcac_pkg::OP_TAB:   ew = tcac_pkg::TAB_WRITES;
				tcac_pkg::OP_NEWLINE: begin
					ecol = '0;
					if (row_q == LAST_ROW)
						es = 1'b1;
					else
						erow = row_q + 1'b1;
				end
				tcac_pkg::OP_BACKSPACE: begin
					// nothing to erase at the origin
					if (col_q != '0 || row_q != '0) begin
						eb = 1'b1;
						if (col_q == '0) begin
							ecol = LAST_COL;
							erow = row_q - 1'b1;
						end else begin
							ecol = col_q - 1'b1;
						end
					end
				end
				default: ec = 1'b1;
			endcase
		end
	end

	assign emit     = (eb || es || ec || (ew != '0)) && !res_full;
	assign res_push = emit;
	assign cmd_pop  = load && !res_full;

	always_comb begin
		ncol     = ecol;
		nrow     = erow;
		nb       = eb;
		ns       = es;
		nw       = ew;
		nc       = ec;
		res_kind = tcac_pkg::KIND_CURSOR;
		if (eb) begin
			res_kind = tcac_pkg::KIND_WRITE;
			nb       = 1'b0;
		end else if (es) begin
			res_kind = tcac_pkg::KIND_SCROLL;
			ns       = 1'b0;
		end else if (ew != '0) begin
			res_kind = tcac_pkg::KIND_WRITE;
			nw       = ew - 1'b1;
			if (ecol == LAST_COL) begin
				ncol = '0;
				if (erow == LAST_ROW)
					ns = 1'b1;
				else
					nrow = erow + 1'b1;
			end else begin
				ncol = ecol + 1'b1;
			end
		end else begin
			nc = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			blank_q   <= 1'b0;
			scroll_q  <= 1'b0;
			wr_left_q <= '0;
			cursor_q  <= 1'b0;
		end else if (emit) begin
			col_q     <= ncol;
			row_q     <= nrow;
			blank_q   <= nb;
			scroll_q  <= ns;
			wr_left_q <= nw;
			cursor_q  <= nc;
		end
	end

endmodule

FILE: sv/text_console_ansi_color.sv
// Top level of the ANSI color text console sink.
//
// Input channel: a byte is transferred on a clock edge with push high and
// full low. Result channel: while empty is low, kind shows the oldest
// result (0 cell write, 1 scroll up with blank fill, 2 cursor update); it
// is transferred on an edge with pop high and empty low.
// The front end parses escape sequences and classifies one byte per
// cycle into a command queue while it has room. The back end owns the
// cursor and emits one result per cycle into the result queue while it
// has room. A byte yields one to six results (a tab writes four cells and
// scrolls at most once on a screen of four or more columns); every byte
// ends with a cursor update. A byte's command goes through the command
// queue and its results through the result queue. The sustained rate is
// one result per cycle while the result queue has room, set by the back
// end; bytes are taken every cycle while the command queue has room.
// When the receiver stalls, the result queue fills, the back end halts,
// and full rises once the command queue is full too. Reset clears both
// queues, puts the cursor at the origin, the attribute at light grey on
// black and the parser in its normal state.
`timescale 1ns / 1ps
module text_console_ansi_color #(
	parameter int COLUMNS = tcac_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcac_pkg::ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind
);
	localparam int OPW = $bits(tcac_pkg::op_t);

	logic                  cmd_push, cmd_full, cmd_empty, cmd_pop;
	tcac_pkg::op_t         front_op, back_op;
	logic [OPW-1:0]        cmd_rdata;
	logic                  res_push, res_full;
	tcac_pkg::kind_t       res_kind;

	assign full    = cmd_full;
	assign back_op = tcac_pkg::op_t'(cmd_rdata);

	tcac_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_byte  (in_byte),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd_op   (front_op)
	);

	tcac_fifo #(
		.WIDTH (OPW),
		.DEPTH (tcac_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (OPW'(front_op)),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	tcac_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd_op    (back_op),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_kind  (res_kind)
	);

	tcac_fifo #(
		.WIDTH (2),
		.DEPTH (tcac_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (2'(res_kind)),
		.full   (res_full),
		.pop    (pop),
		.rdata  (kind),
		.empty  (empty)
	);

endmodule

FILE: tb/sv/text_console_ansi_color_test.sv
// Self-checking testbench for the text console block: directed table, random streams, stalls.
`timescale 1ns / 1ps
module text_console_ansi_color_test;
	import tcac_pkg::*;

	localparam int COLS          = COLUMNS_DEF;
	localparam int LINES         = ROWS_DEF;
	localparam int RANDOM_ITEMS  = 295;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int PAUSE_AT      = 140;
	localparam int STEADY_FROM   = 200;
	localparam int STEADY_TO     = 260;
	localparam int IDLE_PCT      = 35;

	// one byte of the stream; n_lit > 0 means the expected kinds are typed in
	typedef struct packed {
		logic [7:0] b;
		logic [1:0] n_lit;
		kind_t      k0;
		kind_t      k1;
	} stim_row_t;

	localparam int DIRECTED_COUNT = 25;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{CH_BS,     2'd1, KIND_CURSOR, KIND_WRITE},  // backspace at origin
		'{8'h41,     2'd2, KIND_WRITE,  KIND_CURSOR},
		'{CH_BS,     2'd2, KIND_WRITE,  KIND_CURSOR},
		'{8'h00,     2'd2, KIND_WRITE,  KIND_CURSOR}, // control bytes print
		'{8'hFF,     2'd2, KIND_WRITE,  KIND_CURSOR},
		'{CH_TAB,    2'd0, KIND_WRITE,  KIND_WRITE},
		'{CH_LF,     2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_BS,     2'd2, KIND_WRITE,  KIND_CURSOR}, // back to last column of row 0
		'{CH_ESC,    2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_ESC,    2'd1, KIND_CURSOR, KIND_WRITE},  // second ESC keeps waiting
		'{8'h42,     2'd2, KIND_WRITE,  KIND_CURSOR}, // stray ESC dropped, wraps
		'{CH_ESC,    2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_LBRACK, 2'd1, KIND_CURSOR, KIND_WRITE},
		'{8'h39,     2'd1, KIND_CURSOR, KIND_WRITE},
		'{8'h37,     2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_M,      2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_ESC,    2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_LBRACK, 2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_M,      2'd1, KIND_CURSOR, KIND_WRITE},  // empty parameter resets color
		'{CH_ESC,    2'd1, KIND_CURSOR, KIND_WRITE},
		'{CH_LBRACK, 2'd1, KIND_CURSOR, KIND_WRITE},
		'{8'h31,     2'd1, KIND_CURSOR, KIND_WRITE},
		'{8'h30,     2'd1, KIND_CURSOR, KIND_WRITE},
		'{8'h37,     2'd1, KIND_CURSOR, KIND_WRITE},
		'{8'h5A,     2'd1, KIND_CURSOR, KIND_WRITE}   // swallowed after three chars
	};

	localparam logic [2:0] PALETTE_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [1:0] kind;

	text_console_ansi_color u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_byte (in_byte),
		.empty   (empty),
		.pop     (pop),
		.kind    (kind)
	);

	always #6 clk = ~clk;

	// console state as the predictor sees it
	logic [6:0] cur_col = '0;
	logic [4:0] cur_row = '0;
	logic [7:0] attr = ATTR_RESET;
	parse_t     parse_mode = PM_NORMAL;
	logic [1:0] csi_count = '0;
	logic [9:0] csi_value = '0;
	logic       digits_ended = 1'b0;

	stim_row_t   byte_stream [$];
	kind_t       step_kinds [$];
	kind_t       expected_kinds [$];
	kind_t       exp_kind;
	stim_row_t   taken_row;
	int unsigned n_taken = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	bit          held = 1'b0;

	function automatic void wrap_cursor();
		if (cur_col >= 7'(COLS)) begin
			cur_col = '0;
			cur_row++;
		end
		if (cur_row >= 5'(LINES)) begin
			step_kinds.push_back(KIND_SCROLL);
			cur_row = 5'(LINES - 1);
		end
	endfunction

	function automatic void write_cell();
		step_kinds.push_back(KIND_WRITE);
		cur_col++;
		wrap_cursor();
	endfunction

	function automatic void set_color();
		if (csi_value == 10'd0)
			attr = ATTR_RESET;
		else if (csi_value >= 10'd30 && csi_value <= 10'd37)
			attr[3:0] = {1'b0, PALETTE_MAP[3'(csi_value - 10'd30)]};
		else if (csi_value >= 10'd90 && csi_value <= 10'd97)
			attr[3:0] = {1'b1, PALETTE_MAP[3'(csi_value - 10'd90)]};
		else if (csi_value >= 10'd40 && csi_value <= 10'd47)
			attr[7:4] = {1'b0, PALETTE_MAP[3'(csi_value - 10'd40)]};
		else if (csi_value >= 10'd100 && csi_value <= 10'd107)
			attr[7:4] = {1'b1, PALETTE_MAP[3'(csi_value - 10'd100)]};
		parse_mode = PM_NORMAL;
	endfunction

	function automatic void normal_byte(input logic [7:0] b);
		case (b)
			CH_ESC: parse_mode = PM_ESC;
			CH_LF: begin
				cur_col = 7'(COLS);
				wrap_cursor();
			end
			CH_BS: begin
				if (cur_col != '0 || cur_row != '0) begin
					if (cur_col == '0) begin
						cur_col = 7'(COLS - 1);
						cur_row--;
					end else begin
						cur_col--;
					end
					step_kinds.push_back(KIND_WRITE);
				end
			end
			CH_TAB: repeat (TAB_WRITES) write_cell();
			default: write_cell();
		endcase
	endfunction

	// kinds produced by one byte, left in step_kinds
	function automatic void console_step(input logic [7:0] b);
		step_kinds.delete();
		case (parse_mode)
			PM_NORMAL: normal_byte(b);
			PM_ESC: begin
				if (b == CH_LBRACK) begin
					parse_mode = PM_CSI;
					csi_count = '0;
					csi_value = '0;
					digits_ended = 1'b0;
				end else if (b != CH_ESC) begin
					parse_mode = PM_NORMAL;
					normal_byte(b);
				end
			end
			PM_CSI: begin
				if (b == CH_M) begin
					set_color();
				end else begin
					if (!digits_ended && b >= CH_ZERO && b <= CH_NINE)
						csi_value = 10'(csi_value * 10 + (b - CH_ZERO));
					else
						digits_ended = 1'b1;
					csi_count++;
					if (csi_count == 2'd3)
						parse_mode = PM_SKIP;
				end
			end
			default: set_color();
		endcase
		step_kinds.push_back(KIND_CURSOR);
	endfunction

	task automatic add_byte(input logic [7:0] b);
		byte_stream.push_back(stim_row_t'{b, 2'd0, KIND_WRITE, KIND_WRITE});
	endtask

	task automatic build_stream();
		int unsigned pick;
		int unsigned code;
		string digits;
		foreach (DIRECTED_ROWS[i])
			byte_stream.push_back(DIRECTED_ROWS[i]);
		while (byte_stream.size() < DIRECTED_COUNT + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
			end else if (pick < 45) begin
				repeat ($urandom_range(1, 5)) add_byte(CH_LF);
			end else if (pick < 52) begin
				repeat ($urandom_range(1, 3)) add_byte(CH_TAB);
			end else if (pick < 60) begin
				repeat ($urandom_range(1, 4)) add_byte(CH_BS);
			end else if (pick < 78) begin
				// well-formed color sequence
				case ($urandom_range(0, 5))
					0: code = 0;
					1: code = 30 + $urandom_range(0, 7);
					2: code = 90 + $urandom_range(0, 7);
					3: code = 40 + $urandom_range(0, 7);
					4: code = 100 + $urandom_range(0, 7);
					default: code = $urandom_range(0, 999);
				endcase
				add_byte(CH_ESC);
				add_byte(CH_LBRACK);
				if (code != 0 || $urandom_range(0, 1) == 0) begin
					digits = $sformatf("%0d", code);
					for (int k = 0; k < digits.len(); k++)
						add_byte(digits[k]);
				end
				add_byte(CH_M);
			end else if (pick < 90) begin
				// broken or odd sequences
				add_byte(CH_ESC);
				case ($urandom_range(0, 2))
					0: add_byte(8'($urandom_range(0, 255)));
					1: begin
						add_byte(CH_LBRACK);
						repeat ($urandom_range(1, 4))
							add_byte(8'($urandom_range(8'h20, 8'h7F)));
					end
					default: begin
						add_byte(CH_LBRACK);
						add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
						add_byte(8'($urandom_range(8'h3A, 8'h6C)));
						add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
						add_byte(CH_M);
					end
				endcase
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// transfer monitor: input side first so predictions precede checks
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				taken_row = byte_stream[n_taken];
				console_step(in_byte);
				if (taken_row.n_lit != 2'd0) begin
					expected_kinds.push_back(taken_row.k0);
					if (taken_row.n_lit == 2'd2)
						expected_kinds.push_back(taken_row.k1);
				end else begin
					foreach (step_kinds[j])
						expected_kinds.push_back(step_kinds[j]);
				end
				n_taken++;
			end
			if (pop && !empty) begin
				if (expected_kinds.size() == 0) begin
					$display("%0t: unexpected result, kind %0d with nothing expected",
						$time, kind);
					errors++;
				end else begin
					exp_kind = expected_kinds.pop_front();
					if (kind !== exp_kind) begin
						$display("%0t: kind mismatch, expected %0d, actual %0d",
							$time, exp_kind, kind);
						errors++;
					end
				end
			end
		end
	end

	// result side: random stalls, one long hold-off, one stall-free stretch
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && n_taken >= HOLD_AT) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= (n_taken >= STEADY_FROM && n_taken < STEADY_TO) ||
					($urandom_range(0, 99) >= IDLE_PCT);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("text_console_ansi_color_test NOT OK");
			$finish;
		end
	end

	initial begin
		build_stream();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < byte_stream.size(); i++) begin
			if (i == PAUSE_AT) begin
				// let the block drain completely
				push <= 1'b0;
				do @(posedge clk); while (expected_kinds.size() != 0);
			end
			if (i < STEADY_FROM || i >= STEADY_TO) begin
				while ($urandom_range(0, 99) < IDLE_PCT) begin
					push <= 1'b0;
					@(posedge clk);
				end
			end
			push <= 1'b1;
			in_byte <= byte_stream[i].b;
			do @(posedge clk); while (full);
		end
		push <= 1'b0;
		do @(posedge clk); while (expected_kinds.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_kinds.size() == 0)
			$display("text_console_ansi_color_test OK");
		else
			$display("text_console_ansi_color_test NOT OK");
		$finish;
	end

endmodule
